@@ hw/rtl/northwest_corner_allocation_macros.svh @@
// Assertion macros for the allocation block's RTL; nwca_ctrl includes them.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef NORTHWEST_CORNER_ALLOCATION_MACROS_SVH
`define NORTHWEST_CORNER_ALLOCATION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NWCA_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NWCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/nwca_pkg.sv @@
// Shared types, codes and constants of the northwest-corner allocation block.
// No dependencies; every RTL module imports it.
`timescale 1ns / 1ps

package nwca_pkg;

  localparam int MAX_SUPPLIERS_DEF = 16;
  localparam int MAX_CONSUMERS_DEF = 16;

  localparam int AMT_W = 16;  // stock, demand and quantity in whole units
  localparam int ACC_W = 20;  // sums and the dummy demand
  localparam int CNT_W = 5;   // configuration register width

  // Input actions.
  localparam logic [1:0] ACT_LOAD_SUPPLY = 2'd0;
  localparam logic [1:0] ACT_LOAD_DEMAND = 2'd1;
  localparam logic [1:0] ACT_SOLVE       = 2'd2;

  // Result status codes.
  localparam logic [1:0] STS_ALLOC = 2'd0;
  localparam logic [1:0] STS_SHORT = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_SUPPLIER_COUNT = 1'b0;
  localparam logic CFG_CONSUMER_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]       action;
    logic [3:0]       index;
    logic [AMT_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [3:0]       row;
    logic [4:0]       column;
    logic             is_dummy;
    logic [AMT_W-1:0] quantity;
    logic             last;
  } out_item_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ACC_W-1:0] res;
    logic             borrow;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM_S,
    S_SUM_D,
    S_CMP,
    S_ROW,
    S_LOAD,
    S_DLOAD,
    S_COL_CMP,
    S_COL_UPD,
    S_FINISH
  } ctrl_state_t;

endpackage

@@ hw/rtl/nwca_alu.sv @@
// Shared 20-bit add/subtract unit used for the sums, the balance check and
// every cell update. Depends on nwca_pkg.
`timescale 1ns / 1ps

module nwca_alu
  import nwca_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [ACC_W:0] full;

  always_comb begin
    unique case (req.op)
      ALU_ADD: full = {1'b0, req.a} + {1'b0, req.b};
      ALU_SUB: full = {1'b0, req.a} - {1'b0, req.b};
      default: full = '0;
    endcase
    rsp.res    = full[ACC_W-1:0];
    rsp.borrow = (req.op == ALU_SUB) & full[ACC_W];
  end

endmodule

@@ hw/rtl/nwca_ctrl.sv @@
// Sequencer of the allocation block: stock and demand memories, the sum,
// balance and cell-walk steps, and the one-result hold that sets the last flag.
// Depends on nwca_pkg, the assertion macros and an external nwca_alu.
`timescale 1ns / 1ps
`include "northwest_corner_allocation_macros.svh"

module nwca_ctrl
  import nwca_pkg::*;
#(
  parameter int MAX_SUPPLIERS = MAX_SUPPLIERS_DEF,
  parameter int MAX_CONSUMERS = MAX_CONSUMERS_DEF,
  localparam int RCW = $clog2(MAX_SUPPLIERS + 1),
  localparam int CCW = $clog2(MAX_CONSUMERS + 2)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_data,
  input  logic [RCW-1:0]  rows_i,
  input  logic [CCW-1:0]  cols_i,
  output logic            res_valid,
  input  logic            res_ready,
  output out_item_t       res_data,
  output alu_req_t        alu_req,
  input  alu_rsp_t        alu_rsp
);

  localparam int RAW    = (MAX_SUPPLIERS > 1) ? $clog2(MAX_SUPPLIERS) : 1;
  localparam int DAW    = $clog2(MAX_CONSUMERS + 1);
  localparam int DDEPTH = MAX_CONSUMERS + 1;

  // Stock and demand stores; the extra demand entry takes the dummy consumer.
  logic [AMT_W-1:0] supply_mem_r [MAX_SUPPLIERS];
  logic [ACC_W-1:0] demand_mem_r [DDEPTH];
  logic [AMT_W-1:0] supply_rd_r;
  logic [ACC_W-1:0] demand_rd_r;

  logic             s_we, s_re, d_we, d_re;
  logic [RAW-1:0]   s_waddr, s_raddr;
  logic [DAW-1:0]   d_waddr, d_raddr;
  logic [AMT_W-1:0] s_wdata;
  logic [ACC_W-1:0] d_wdata;

  ctrl_state_t      state_r, state_nxt;
  logic [RCW-1:0]   row_r, row_nxt;
  logic [CCW-1:0]   col_r, col_nxt;
  logic [CCW-1:0]   ncols_r, ncols_nxt;
  logic [ACC_W-1:0] acc_s_r, acc_s_nxt;
  logic [ACC_W-1:0] acc_d_r, acc_d_nxt;
  logic             rdv_r, rdv_nxt;
  logic [AMT_W-1:0] s_r, s_nxt;
  logic [ACC_W-1:0] d_r, d_nxt;
  logic             lt_r, lt_nxt;
  logic             err_r, err_nxt;
  logic             hold_v_r, hold_v_nxt;
  out_item_t        hold_r, hold_nxt;

  logic [ACC_W-1:0] s_ext;
  logic [CCW-1:0]   col_inc;
  logic [AMT_W-1:0] s_new;
  logic [ACC_W-1:0] d_new;
  logic [AMT_W-1:0] qty;

  assign s_ext   = ACC_W'(s_r);
  assign col_inc = CCW'(col_r + 1'b1);

  always_ff @(posedge clk) begin
    if (s_we) begin
      supply_mem_r[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      supply_rd_r <= supply_mem_r[s_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      demand_mem_r[d_waddr] <= d_wdata;
    end
    if (d_re) begin
      demand_rd_r <= demand_mem_r[d_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      row_r    <= '0;
      col_r    <= '0;
      rdv_r    <= 1'b0;
      err_r    <= 1'b0;
      hold_v_r <= 1'b0;
      acc_s_r  <= '0;
      acc_d_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      rdv_r    <= rdv_nxt;
      err_r    <= err_nxt;
      hold_v_r <= hold_v_nxt;
      acc_s_r  <= acc_s_nxt;
      acc_d_r  <= acc_d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ncols_r <= ncols_nxt;
    s_r     <= s_nxt;
    d_r     <= d_nxt;
    lt_r    <= lt_nxt;
    hold_r  <= hold_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    ncols_nxt  = ncols_r;
    acc_s_nxt  = acc_s_r;
    acc_d_nxt  = acc_d_r;
    rdv_nxt    = rdv_r;
    s_nxt      = s_r;
    d_nxt      = d_r;
    lt_nxt     = lt_r;
    err_nxt    = err_r;
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;

    alu_req = '{op: ALU_ADD, a: '0, b: '0};
    s_new   = '0;
    d_new   = '0;
    qty     = '0;

    s_we    = 1'b0;
    s_re    = 1'b0;
    s_waddr = row_r[RAW-1:0];
    s_raddr = row_r[RAW-1:0];
    s_wdata = s_r;
    d_we    = 1'b0;
    d_re    = 1'b0;
    d_waddr = col_r[DAW-1:0];
    d_raddr = col_r[DAW-1:0];
    d_wdata = d_r;

    in_ready  = 1'b0;
    res_valid = 1'b0;
    res_data  = hold_r;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          priority if (in_data.action == ACT_LOAD_SUPPLY) begin
            if (32'(in_data.index) < MAX_SUPPLIERS) begin
              s_we    = 1'b1;
              s_waddr = RAW'(in_data.index);
              s_wdata = in_data.amount;
            end
          end else if (in_data.action == ACT_LOAD_DEMAND) begin
            if (32'(in_data.index) < MAX_CONSUMERS) begin
              d_we    = 1'b1;
              d_waddr = DAW'(in_data.index);
              d_wdata = ACC_W'(in_data.amount);
            end
          end else if (in_data.action == ACT_SOLVE) begin
            state_nxt = S_SUM_S;
            row_nxt   = '0;
            rdv_nxt   = 1'b0;
            acc_s_nxt = '0;
            acc_d_nxt = '0;
            err_nxt   = 1'b0;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      // Read one stock per cycle; each add comes in the cycle after its read.
      S_SUM_S: begin
        if (rdv_r) begin
          alu_req   = '{op: ALU_ADD, a: acc_s_r, b: ACC_W'(supply_rd_r)};
          acc_s_nxt = alu_rsp.res;
        end
        if (row_r != rows_i) begin
          s_re    = 1'b1;
          rdv_nxt = 1'b1;
          row_nxt = RCW'(row_r + 1'b1);
        end else begin
          rdv_nxt = 1'b0;
          if (!rdv_r) begin
            state_nxt = S_SUM_D;
            col_nxt   = '0;
          end
        end
      end

      S_SUM_D: begin
        if (rdv_r) begin
          alu_req   = '{op: ALU_ADD, a: acc_d_r, b: demand_rd_r};
          acc_d_nxt = alu_rsp.res;
        end
        if (col_r != cols_i) begin
          d_re    = 1'b1;
          rdv_nxt = 1'b1;
          col_nxt = col_inc;
        end else begin
          rdv_nxt = 1'b0;
          if (!rdv_r) begin
            state_nxt = S_CMP;
          end
        end
      end

      S_CMP: begin
        alu_req = '{op: ALU_SUB, a: acc_s_r, b: acc_d_r};
        if (alu_rsp.borrow) begin
          err_nxt   = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          // Surplus supply goes to a dummy consumer after the real ones.
          if (alu_rsp.res != '0) begin
            d_we      = 1'b1;
            d_waddr   = DAW'(cols_i);
            d_wdata   = alu_rsp.res;
            ncols_nxt = CCW'(cols_i + 1'b1);
          end else begin
            ncols_nxt = cols_i;
          end
          row_nxt   = '0;
          col_nxt   = '0;
          state_nxt = S_ROW;
        end
      end

      // Columns left of the column pointer are exhausted, so a new row
      // resumes where the previous one stopped.
      S_ROW: begin
        if (row_r == rows_i || col_r == ncols_r) begin
          state_nxt = S_FINISH;
        end else begin
          s_re      = 1'b1;
          d_re      = 1'b1;
          state_nxt = S_LOAD;
        end
      end

      S_LOAD: begin
        s_nxt     = supply_rd_r;
        d_nxt     = demand_rd_r;
        state_nxt = S_COL_CMP;
      end

      S_DLOAD: begin
        d_nxt     = demand_rd_r;
        state_nxt = S_COL_CMP;
      end

      S_COL_CMP: begin
        if (d_r == '0) begin
          col_nxt = col_inc;
          if (col_inc == ncols_r) begin
            state_nxt = S_FINISH;
          end else begin
            d_re      = 1'b1;
            d_raddr   = col_inc[DAW-1:0];
            state_nxt = S_DLOAD;
          end
        end else begin
          alu_req   = '{op: ALU_SUB, a: s_ext, b: d_r};
          lt_nxt    = alu_rsp.borrow;
          state_nxt = S_COL_UPD;
        end
      end

      // The new allocation goes into the hold; the one already there leaves.
      S_COL_UPD: begin
        res_valid = hold_v_r;
        if (!hold_v_r || res_ready) begin
          if (lt_r) begin
            alu_req = '{op: ALU_SUB, a: d_r, b: s_ext};
            d_new   = alu_rsp.res;
            s_new   = '0;
            qty     = s_r;
          end else begin
            alu_req = '{op: ALU_SUB, a: s_ext, b: d_r};
            d_new   = '0;
            s_new   = alu_rsp.res[AMT_W-1:0];
            qty     = d_r[AMT_W-1:0];
          end
          s_we       = 1'b1;
          s_wdata    = s_new;
          d_we       = 1'b1;
          d_wdata    = d_new;
          hold_v_nxt = 1'b1;
          hold_nxt   = '{status: STS_ALLOC, row: 4'(row_r), column: 5'(col_r),
                         is_dummy: (col_r == cols_i), quantity: qty, last: 1'b0};
          if (s_new == '0) begin
            row_nxt   = RCW'(row_r + 1'b1);
            state_nxt = S_ROW;
          end else begin
            s_nxt   = s_new;
            col_nxt = col_inc;
            if (col_inc == ncols_r) begin
              state_nxt = S_FINISH;
            end else begin
              d_re      = 1'b1;
              d_raddr   = col_inc[DAW-1:0];
              state_nxt = S_DLOAD;
            end
          end
        end
      end

      S_FINISH: begin
        res_valid = 1'b1;
        priority if (err_r) begin
          res_data = '{status: STS_SHORT, row: '0, column: '0, is_dummy: 1'b0,
                       quantity: '0, last: 1'b1};
        end else if (hold_v_r) begin
          res_data      = hold_r;
          res_data.last = 1'b1;
        end else begin
          res_data = '{status: STS_EMPTY, row: '0, column: '0, is_dummy: 1'b0,
                       quantity: '0, last: 1'b1};
        end
        if (res_ready) begin
          hold_v_nxt = 1'b0;
          err_nxt    = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `NWCA_ASSERT(a_idle_hold_empty, state_r == S_IDLE, !hold_v_r, "hold valid while idle")
  `NWCA_ASSERT(a_col_in_range, state_r == S_COL_CMP, col_r < ncols_r, "column past end")
  `NWCA_ASSERT(a_lt_consistent, state_r == S_COL_UPD, lt_r == (s_ext < d_r), "stale compare")
  `NWCA_ASSERT_NEXT(a_finish_idle, (state_r == S_FINISH) && res_ready, state_r == S_IDLE, "no return to idle")

endmodule

@@ hw/rtl/northwest_corner_allocation.sv @@
//   Channel  Direction  Handshake          Beat
//   in_      input      in_valid/in_ready  action, index, amount
//   out_     output     out_valid/out_ready status, row, column, is_dummy, quantity, last
//   cfg_     input      cfg_we             register index and 5-bit value, no wait
// Load beats are accepted while the sequencer is idle. After it accepts a solve, the block forms the
// stock sum, then the demand sum, then runs the balance check. The walk then passes S_ROW, S_LOAD,
// S_COL_CMP and S_COL_UPD for the first cell of a row, S_DLOAD, S_COL_CMP and S_COL_UPD for each further
// cell, S_COL_CMP and S_DLOAD for each empty column skipped, and S_FINISH for the last beat.
// Reset is synchronous and needs no clearing pass; both counts reset to 1.
// A stalled output holds the walk once the one-deep hold and the output register are full.
// Top level: count registers, output register, sequencer and shared unit.
// Depends on nwca_pkg, nwca_ctrl and nwca_alu.
`timescale 1ns / 1ps

module northwest_corner_allocation
  import nwca_pkg::*;
#(
  parameter int MAX_SUPPLIERS = MAX_SUPPLIERS_DEF,
  parameter int MAX_CONSUMERS = MAX_CONSUMERS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CNT_W-1:0] cfg_wdata
);

  localparam int RCW = $clog2(MAX_SUPPLIERS + 1);
  localparam int CCW = $clog2(MAX_CONSUMERS + 2);

  logic [CNT_W-1:0] sup_cnt_r;
  logic [CNT_W-1:0] con_cnt_r;
  logic [RCW-1:0]   rows;
  logic [CCW-1:0]   cols;

  logic      res_valid;
  logic      res_ready;
  out_item_t res_data;
  logic      out_valid_r;
  out_item_t out_data_r;
  alu_req_t  alu_req;
  alu_rsp_t  alu_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sup_cnt_r <= CNT_W'(1);
      con_cnt_r <= CNT_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == CFG_SUPPLIER_COUNT) begin
        sup_cnt_r <= cfg_wdata;
      end else if (cfg_index == CFG_CONSUMER_COUNT) begin
        con_cnt_r <= cfg_wdata;
      end
    end
  end

  // A zero count acts as one and a count past the store depth as the depth.
  always_comb begin
    if (sup_cnt_r == '0) begin
      rows = RCW'(1);
    end else if (32'(sup_cnt_r) > MAX_SUPPLIERS) begin
      rows = RCW'(MAX_SUPPLIERS);
    end else begin
      rows = RCW'(sup_cnt_r);
    end
    if (con_cnt_r == '0) begin
      cols = CCW'(1);
    end else if (32'(con_cnt_r) > MAX_CONSUMERS) begin
      cols = CCW'(MAX_CONSUMERS);
    end else begin
      cols = CCW'(con_cnt_r);
    end
  end

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  nwca_ctrl #(
    .MAX_SUPPLIERS (MAX_SUPPLIERS),
    .MAX_CONSUMERS (MAX_CONSUMERS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .rows_i    (rows),
    .cols_i    (cols),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .alu_req   (alu_req),
    .alu_rsp   (alu_rsp)
  );

  nwca_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

endmodule
